[rtl/isrt_pkg.sv]
package isrt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 17;

	// one stored slot of the chain
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} isrt_entry_t;

	// key travelling down the chain; shift marks a displaced key that only moves on
	typedef struct packed {
		logic             valid;
		logic             shift;
		logic             order;
		logic [KEY_W-1:0] key;
	} isrt_carry_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} isrt_state_t;

	// true when key must be placed ahead of stored key s
	function automatic logic goes_before(input logic order, input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] s);
		goes_before = order ? (key > s) : (key < s);
	endfunction

endpackage

[rtl/isrt_cell.sv]
module isrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 unload,
	input  isrt_pkg::isrt_carry_t carry_in,
	input  isrt_pkg::isrt_entry_t right_entry,
	output isrt_pkg::isrt_entry_t entry,
	output isrt_pkg::isrt_carry_t carry_out
);
	import isrt_pkg::*;

	isrt_entry_t entry_q;
	isrt_carry_t carry_q;
	isrt_entry_t entry_d;
	isrt_carry_t carry_d;

	always_comb begin
		entry_d = entry_q;
		carry_d = '0;
		if (unload) begin
			entry_d = right_entry;
		end else if (carry_in.valid) begin
			if (!entry_q.valid) begin
				entry_d = '{valid: 1'b1, key: carry_in.key};
			end else if (carry_in.shift ||
					goes_before(carry_in.order, carry_in.key, entry_q.key)) begin
				// take the key here, push the held one onwards
				entry_d = '{valid: 1'b1, key: carry_in.key};
				carry_d = '{valid: 1'b1, shift: 1'b1, order: carry_in.order,
					key: entry_q.key};
			end else begin
				carry_d = carry_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			carry_q <= '0;
		end else begin
			entry_q <= entry_d;
			carry_q <= carry_d;
		end
	end

	assign entry     = entry_q;
	assign carry_out = carry_q;

endmodule

[rtl/insertion_sorter.sv]
// stable insertion sorter built as a row of CAPACITY compare-and-hold cells
// request channel: a key is taken on a clock edge with start high and busy low;
//   last_item marks the final key of a data set
// while loading, one key is taken every cycle: each key walks down the row one
//   cell per cycle, settles in front of the first held key it must precede
//   (behind equal keys) and the keys it displaces ripple on behind it
// a key arriving with the row full is dropped and the set is flagged overflowed
// after the last key, busy stays high while the row settles and while the held
//   keys leave the head of the row one per cycle
// results: result_valid is a one-cycle strobe with sorted_value, final_result
//   (set on the last key of the set) and overflowed; the receiver cannot stall,
//   each result is taken on the edge that ends its cycle
// configuration: cfg_data carries sort_order (0 ascending, 1 descending), always
//   ready; each key is placed using the order in force when it was taken
// reset clears the row, the fill count, the overflow flag and sort_order
module insertion_sorter #(
	parameter int CAPACITY = isrt_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [isrt_pkg::KEY_W-1:0] key_value,
	input  logic                       last_item,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	output logic                       result_valid,
	output logic [isrt_pkg::KEY_W-1:0] sorted_value,
	output logic                       final_result,
	output logic                       overflowed
);
	import isrt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	isrt_state_t state_q, state_d;

	logic             sort_order_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic             overflow_q;

	logic             accept;
	logic             full;
	logic [CNT_W-1:0] fill_next;
	logic             unload;
	logic             cnt_last;

	logic             res_valid_q;
	logic [KEY_W-1:0] res_key_q;
	logic             res_final_q;
	logic             res_ovf_q;

	isrt_carry_t carry_w [0:CAPACITY];
	isrt_entry_t entry_w [0:CAPACITY];

	assign accept    = start && !busy;
	assign full      = (fill_q == CNT_W'(CAPACITY));
	assign fill_next = full ? fill_q : fill_q + CNT_W'(1);
	assign cnt_last  = (cnt_q == CNT_W'(1));
	assign cfg_ready = 1'b1;

	// new key enters the head cell, unless the row is full
	assign carry_w[0] = '{valid: accept && !full, shift: 1'b0, order: sort_order_q,
		key: key_value};
	assign entry_w[CAPACITY] = '0;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			isrt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.unload     (unload),
				.carry_in   (carry_w[g]),
				.right_entry(entry_w[g+1]),
				.entry      (entry_w[g]),
				.carry_out  (carry_w[g+1])
			);
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && last_item) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (cnt_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cnt_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b1;
		unload = 1'b0;
		case (state_q)
			ST_LOAD:  busy = 1'b0;
			ST_DRAIN: busy = 1'b1;
			ST_EMIT:  unload = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			sort_order_q <= 1'b0;
			fill_q       <= '0;
			cnt_q        <= '0;
			overflow_q   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) sort_order_q <= cfg_data;
			res_valid_q <= unload;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						fill_q <= fill_next;
						if (full) overflow_q <= 1'b1;
						// the settle counter is loaded with the count held
						if (last_item) cnt_q <= fill_next;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_last ? fill_q : cnt_q - CNT_W'(1);
				end
				ST_EMIT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_last) begin
						fill_q     <= '0;
						overflow_q <= 1'b0;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// result register, fed from the head cell
	always_ff @(posedge clk) begin
		res_key_q   <= entry_w[0].key;
		res_final_q <= cnt_last;
		res_ovf_q   <= overflow_q;
	end

	assign result_valid = res_valid_q;
	assign sorted_value = res_key_q;
	assign final_result = res_final_q;
	assign overflowed   = res_ovf_q;

endmodule

[dv/tb_insertion_sorter.sv]
`timescale 1ns / 100ps

module tb_insertion_sorter;

	localparam int CAP       = isrt_pkg::CAPACITY_DEF;
	localparam int KW        = isrt_pkg::KEY_W;
	localparam int KEY_HIGH  = 99999;       // top of the nominal key range, 999.99
	localparam int N_KEYS    = 210;         // rough size of the whole run in requests
	localparam int SETTLE    = 2 * CAP + 8; // a key may still be walking the row this long
	localparam int TAIL      = 2 * CAP + 8;
	localparam int CALM_TAIL = 30;          // no sender gaps over the last stretch
	localparam int WATCHDOG  = 4000;
	localparam int SHOW_MAX  = 10;

	typedef enum logic {ORDER_ASCENDING, ORDER_DESCENDING} order_e;
	typedef enum logic {PLAN_KEY, PLAN_ORDER} plan_e;

	// one step of the stimulus plan: a key request or a sort order write
	typedef struct packed {
		plan_e         kind;
		logic [KW-1:0] key;
		logic          last;
		order_e        order;
	} plan_t;

	// one key as it should leave the block
	typedef struct packed {
		logic [KW-1:0] key;
		logic          fin;
		logic          ovf;
	} emit_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [KW-1:0] key_value = '0;
	logic          last_item = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_data = 1'b0;
	logic          result_valid;
	logic [KW-1:0] sorted_value;
	logic          final_result;
	logic          overflowed;

	insertion_sorter #(
		.CAPACITY(CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.key_value    (key_value),
		.last_item    (last_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.final_result (final_result),
		.overflowed   (overflowed)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// shadow of the sorter: its own row of held keys, fill count and drop flag
	logic [KW-1:0] held_keys [CAP];
	int            held_count = 0;
	logic          dropped = 1'b0;
	order_e        model_order = ORDER_ASCENDING;

	emit_t         due_keys [$];   // keys still owed by the block, oldest first
	plan_t         key_plan [$];   // requests and order writes not yet taken
	int            planned_keys = 0;
	int            faults = 0;

	// handshakes seen at the last rising edge, for the driver at the falling edge
	logic          req_taken = 1'b0;
	logic          cfg_taken = 1'b0;

	// driver bookkeeping
	logic          on_port = 1'b0;
	int            gap_left = 0;
	int            settle = 0;
	int            stall_cycles = 0;

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= SHOW_MAX) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// insert one key behind any equal ones, then on the last key owe the whole row
	function automatic void place_key(input logic [KW-1:0] k, input logic lst);
		int pos;
		if (held_count < CAP) begin
			pos = 0;
			// each key is placed by the order in force when it is taken
			while (pos < held_count && !(model_order == ORDER_DESCENDING ?
					k > held_keys[pos] : k < held_keys[pos])) begin
				pos++;
			end
			for (int i = held_count; i > pos; i--) begin
				held_keys[i] = held_keys[i - 1];
			end
			held_keys[pos] = k;
			held_count++;
		end else begin
			// row full: the key is lost and the whole set is flagged
			dropped = 1'b1;
		end
		if (lst) begin
			for (int i = 0; i < held_count; i++) begin
				due_keys.push_back(emit_t'{key: held_keys[i], fin: (i == held_count - 1),
					ovf: dropped});
			end
			held_count = 0;
			dropped = 1'b0;
		end
	endfunction

	function automatic void add_key(input logic [KW-1:0] k, input logic lst);
		key_plan.push_back(plan_t'{kind: PLAN_KEY, key: k, last: lst, order: ORDER_ASCENDING});
		planned_keys++;
	endfunction

	function automatic void add_order(input order_e o);
		key_plan.push_back(plan_t'{kind: PLAN_ORDER, key: '0, last: 1'b0, order: o});
	endfunction

	// mix of wide random keys, in-range keys, tiny keys for ties and the edges
	function automatic logic [KW-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return KW'($urandom_range(0, (1 << KW) - 1));
			4, 5:       return KW'($urandom_range(0, KEY_HIGH));
			6, 7:       return KW'($urandom_range(0, 7));
			8: begin
				case ($urandom_range(0, 2))
					0:       return '0;
					1:       return '1;
					default: return KW'(KEY_HIGH);
				endcase
			end
			default:    return KW'($urandom_range(KEY_HIGH - 3, KEY_HIGH + 3));
		endcase
	endfunction

	function automatic void add_keys(input int len, input bit closes);
		for (int i = 0; i < len; i++) begin
			add_key(pick_key(), closes && (i == len - 1));
		end
	endfunction

	// driver: works through the plan at the falling edge, one request at a time
	always @(negedge clk) begin : drive
		logic          n_start;
		logic          n_last;
		logic          n_cfg_valid;
		logic          n_cfg;
		logic [KW-1:0] n_key;
		plan_t         head;
		n_start     = start;
		n_last      = last_item;
		n_cfg_valid = cfg_valid;
		n_cfg       = cfg_data;
		n_key       = key_value;
		if (arst_n) begin
			// the request on the port went in at the last rising edge
			if (req_taken || cfg_taken) begin
				head        = key_plan.pop_front();
				on_port     = 1'b0;
				n_start     = 1'b0;
				n_cfg_valid = 1'b0;
			end
			if (!on_port) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (key_plan.size() != 0) begin
					head = key_plan[0];
					if (head.kind == PLAN_KEY) begin
						// start stays high across back-to-back requests
						n_start = 1'b1;
						n_key   = head.key;
						n_last  = head.last;
						on_port = 1'b1;
						if (key_plan.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
							gap_left = $urandom_range(1, 4);
						end
					end else if (due_keys.size() != 0) begin
						settle = 0;
					end else if (settle < SETTLE) begin
						// nothing owed, but keys may still be travelling down the row
						settle++;
					end else begin
						n_cfg_valid = 1'b1;
						n_cfg       = head.order;
						on_port     = 1'b1;
						settle      = 0;
					end
				end
			end
		end
		start     <= n_start;
		key_value <= n_key;
		last_item <= n_last;
		cfg_valid <= n_cfg_valid;
		cfg_data  <= n_cfg;
	end

	// monitor: takes handshakes and results at the rising edge
	always @(posedge clk or negedge arst_n) begin
		emit_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			req_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (result_valid) begin
				if (due_keys.size() == 0) begin
					note_fault($sformatf("unexpected result key %0d final %0b overflow %0b",
						sorted_value, final_result, overflowed));
				end else begin
					want = due_keys.pop_front();
					if (sorted_value !== want.key || final_result !== want.fin ||
							overflowed !== want.ovf) begin
						note_fault($sformatf(
							"result mismatch: key %0d/%0d final %0b/%0b overflow %0b/%0b (exp/act)",
							want.key, sorted_value, want.fin, final_result,
							want.ovf, overflowed));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				model_order = order_e'(cfg_data);
			end
			if (start && !busy) begin
				place_key(key_value, last_item);
			end
			// watchdog on cycles where nothing at all goes in or comes out
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit full_done;
		bit over_done;
		int len;
		int split;
		full_done = 1'b0;
		over_done = 1'b0;

		// lone key straight out of reset, ascending
		add_key('0, 1'b1);
		// extremes, alternating bit patterns, out-of-range and equal keys
		add_key('1, 1'b0);
		add_key(KW'(KEY_HIGH), 1'b0);
		add_key('0, 1'b0);
		add_key(KW'('h15555), 1'b0);
		add_key(KW'(KEY_HIGH), 1'b0);
		add_key(KW'('h0AAAA), 1'b0);
		add_key(KW'(1), 1'b1);
		// same kind of set sorted descending
		add_order(ORDER_DESCENDING);
		add_key(KW'(5), 1'b0);
		add_key('1, 1'b0);
		add_key('0, 1'b0);
		add_key(KW'(5), 1'b0);
		add_key(KW'(12345), 1'b1);
		// order flipped part way through a set
		add_order(ORDER_ASCENDING);
		add_key(KW'(300), 1'b0);
		add_key(KW'(100), 1'b0);
		add_key(KW'(200), 1'b0);
		add_order(ORDER_DESCENDING);
		add_key(KW'(150), 1'b0);
		add_key(KW'(400), 1'b1);
		add_order(ORDER_ASCENDING);

		// random sets: mostly short, one exactly full and one that overflows
		while (planned_keys < N_KEYS || !over_done) begin
			if (!full_done && planned_keys >= 50) begin
				add_keys(CAP, 1'b1);
				full_done = 1'b1;
			end else if (!over_done && planned_keys >= 120) begin
				add_keys(CAP + $urandom_range(1, 4), 1'b1);
				over_done = 1'b1;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
				if (len > 1 && $urandom_range(0, 4) == 0) begin
					split = $urandom_range(1, len - 1);
					add_keys(split, 1'b0);
					add_order(order_e'($urandom_range(0, 1)));
					add_keys(len - split, 1'b1);
				end else begin
					add_keys(len, 1'b1);
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				add_order(order_e'($urandom_range(0, 1)));
			end
		end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// all requests in, then everything owed, then a quiet spell for strays
		while (key_plan.size() != 0) begin
			@(posedge clk);
		end
		while (due_keys.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL) @(negedge clk);

		if (due_keys.size() != 0) begin
			$display("%0d expected results never arrived", due_keys.size());
			faults++;
		end
		if (faults == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
